// ===== rtl/bfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared constants and types of the bit field packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int ROW_W        = ADDR_W - 1;
  localparam int BANK_ROWS    = BUFFER_BYTES / 2;
  localparam int POS_W        = 14;
  localparam int DATA_W       = 8;
  localparam int COUNT_W      = 4;

  localparam logic [POS_W-1:0]   TOTAL_BITS = POS_W'(BUFFER_BYTES * 8);
  localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(8);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              ovf;
    logic [POS_W-1:0]  pos;
  } bfp_result_t;

endpackage

// ===== rtl/bit_field_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_packer_top
// LSB-first bit stream writer into a banked byte buffer, with one result
// transaction per updated byte, or one overflow result for a dropped field.
// ----------------------------------------------------------------------------
// result path: an accepted transaction passes the read stage, then the
//   merge/write stage into the result queue, before its first result is offered
// throughput: one transaction per cycle while the result queue has room; a
//   transaction that crosses a byte boundary yields two results, so the single output port sets the rate then
// reset: synchronous; position and queue clear, no memory sweep
module bit_field_packer_top
  import bfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic [COUNT_W-1:0]  bit_count,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   byte_address,
  output logic [DATA_W-1:0]   byte_value,
  output logic                last,
  output logic                overflow,
  output logic [POS_W-1:0]    bit_position
);

  // --------------------------------------------------------------------------
  // buffer storage: even and odd byte banks, so a field that spills into the
  // next byte writes both bytes in one cycle. a byte is only read back when
  // the bit offset is nonzero, and then it was written by an earlier
  // transaction, so the banks need no clearing pass after reset
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] bank_even [BANK_ROWS];
  logic [DATA_W-1:0] bank_odd  [BANK_ROWS];

  // running write position
  logic [POS_W-1:0] pos;

  // --------------------------------------------------------------------------
  // accept stage: decode against the head position, issue the bank read
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] cnt_sat;
  logic [POS_W-1:0]   next_pos;
  logic               in_ovf;
  logic [DATA_W:0]    field_ones;
  logic [DATA_W-1:0]  data_m;
  logic [ADDR_W-1:0]  byte_idx;
  logic [2:0]         bit_off;
  logic [COUNT_W-1:0] end_bit;
  logic               in_carry;
  logic               take;
  logic [ROW_W-1:0]   rd_row;

  assign cnt_sat    = (bit_count > MAX_COUNT) ? MAX_COUNT : bit_count;
  assign next_pos   = pos + POS_W'(cnt_sat);
  assign in_ovf     = next_pos > TOTAL_BITS;
  assign field_ones = (DATA_W+1)'((DATA_W+1)'(1) << cnt_sat) - (DATA_W+1)'(1);
  assign data_m     = data_byte & field_ones[DATA_W-1:0];
  assign byte_idx   = pos[ADDR_W+2:3];
  assign bit_off    = pos[2:0];
  assign end_bit    = COUNT_W'(bit_off) + cnt_sat;
  assign in_carry   = end_bit > MAX_COUNT;
  // a zero count is taken and dropped without a result
  assign take       = in_valid && in_ready && (bit_count != '0);
  assign rd_row     = byte_idx[ADDR_W-1:1];

  // --------------------------------------------------------------------------
  // merge stage registers
  // --------------------------------------------------------------------------
  logic               s1_valid;
  logic               s1_ovf;
  logic [ADDR_W-1:0]  s1_addr;
  logic [2:0]         s1_off;
  logic [DATA_W-1:0]  s1_data;
  logic               s1_carry;
  logic [POS_W-1:0]   s1_pos;
  logic               s1_fwd_hit;
  logic [DATA_W-1:0]  s1_fwd_data;
  logic [DATA_W-1:0]  rd_even;
  logic [DATA_W-1:0]  rd_odd;

  // merge stage logic
  logic [DATA_W-1:0]   old_byte;
  logic [DATA_W-1:0]   keep_mask;
  logic [2*DATA_W-1:0] shifted;
  logic [DATA_W-1:0]   merged;
  logic [DATA_W-1:0]   hi_byte;
  logic [ADDR_W-1:0]   hi_addr;
  logic                s1_write;

  always_comb begin
    if (s1_fwd_hit) begin
      old_byte = s1_fwd_data;
    end else if (s1_addr[0]) begin
      old_byte = rd_odd;
    end else begin
      old_byte = rd_even;
    end
  end

  assign keep_mask = DATA_W'(DATA_W'(1) << s1_off) - DATA_W'(1);
  assign shifted   = (2*DATA_W)'(s1_data) << s1_off;
  assign merged    = (old_byte & keep_mask) | shifted[DATA_W-1:0];
  assign hi_byte   = shifted[2*DATA_W-1:DATA_W];
  assign hi_addr   = s1_addr + ADDR_W'(1);
  assign s1_write  = s1_valid && !s1_ovf;

  // per-bank write port: the head byte goes to its bank, the spill byte to
  // the other one
  logic              we_even;
  logic              we_odd;
  logic [ROW_W-1:0]  row_even;
  logic [ROW_W-1:0]  row_odd;
  logic [DATA_W-1:0] dat_even;
  logic [DATA_W-1:0] dat_odd;

  always_comb begin
    if (s1_addr[0]) begin
      we_odd   = s1_write;
      row_odd  = s1_addr[ADDR_W-1:1];
      dat_odd  = merged;
      we_even  = s1_write && s1_carry;
      row_even = hi_addr[ADDR_W-1:1];
      dat_even = hi_byte;
    end else begin
      we_even  = s1_write;
      row_even = s1_addr[ADDR_W-1:1];
      dat_even = merged;
      we_odd   = s1_write && s1_carry;
      row_odd  = hi_addr[ADDR_W-1:1];
      dat_odd  = hi_byte;
    end
  end

  // forward a write that lands on the row being read in the same cycle
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;

  always_comb begin
    if (byte_idx[0]) begin
      fwd_hit  = we_odd && (row_odd == rd_row);
      fwd_data = dat_odd;
    end else begin
      fwd_hit  = we_even && (row_even == rd_row);
      fwd_data = dat_even;
    end
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      bank_even[row_even] <= dat_even;
    end
    rd_even <= bank_even[rd_row];
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      bank_odd[row_odd] <= dat_odd;
    end
    rd_odd <= bank_odd[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      if (take && !in_ovf) begin
        pos <= next_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ovf      <= in_ovf;
      s1_addr     <= byte_idx;
      s1_off      <= bit_off;
      s1_data     <= data_m;
      s1_carry    <= in_carry;
      s1_pos      <= in_ovf ? pos : next_pos;
      s1_fwd_hit  <= fwd_hit;
      s1_fwd_data <= fwd_data;
    end
  end

  // --------------------------------------------------------------------------
  // result queue: up to two entries pushed per transaction, one popped
  // --------------------------------------------------------------------------
  bfp_result_t       res0;
  bfp_result_t       res1;
  logic [1:0]        push_n;
  bfp_result_t       fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic               pop;

  always_comb begin
    if (s1_ovf) begin
      res0.addr  = '0;
      res0.value = '0;
      res0.last  = 1'b1;
      res0.ovf   = 1'b1;
    end else begin
      res0.addr  = s1_addr;
      res0.value = merged;
      res0.last  = !s1_carry;
      res0.ovf   = 1'b0;
    end
    res0.pos   = s1_pos;
    res1.addr  = hi_addr;
    res1.value = hi_byte;
    res1.last  = 1'b1;
    res1.ovf   = 1'b0;
    res1.pos   = s1_pos;
  end

  always_comb begin
    if (!s1_valid) begin
      push_n = 2'd0;
    end else if (s1_ovf || !s1_carry) begin
      push_n = 2'd1;
    end else begin
      push_n = 2'd2;
    end
  end

  // room for the transaction in the merge stage and for a new one
  assign in_ready  = ((FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(push_n))
                     <= (FIFO_CW+1)'(FIFO_DEPTH - 2);
  assign out_valid = fifo_count != '0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr + FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  assign byte_address = fifo_q[rd_ptr].addr;
  assign byte_value   = fifo_q[rd_ptr].value;
  assign last         = fifo_q[rd_ptr].last;
  assign overflow     = fifo_q[rd_ptr].ovf;
  assign bit_position = fifo_q[rd_ptr].pos;

endmodule

// ===== tb/bfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_checker
// Watches both channels of the bit field packer. Keeps its own byte image
// and write position, works out the byte updates of every accepted field and
// compares them in order with the result transactions.
// ----------------------------------------------------------------------------
module bfp_checker
  import bfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic [COUNT_W-1:0] bit_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [ADDR_W-1:0]  byte_address,
  input  logic [DATA_W-1:0]  byte_value,
  input  logic               last,
  input  logic               overflow,
  input  logic [POS_W-1:0]   bit_position,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);

  logic [DATA_W-1:0] byte_image [BUFFER_BYTES];
  logic [POS_W-1:0]  stream_pos;
  bfp_result_t       pending_bytes [$];

  // byte updates caused by appending one field
  task automatic pack_field(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count);
    int unsigned nbits;
    int unsigned head;
    int unsigned next_pos;
    int unsigned idx;
    int unsigned off;
    int unsigned room;
    int unsigned field;
    logic [DATA_W-1:0] merged;
    bfp_result_t upd;
    if (count != '0) begin
      nbits    = (count > MAX_COUNT) ? int'(MAX_COUNT) : int'(count);
      head     = 32'(stream_pos);
      next_pos = head + nbits;
      if (next_pos > BUFFER_BYTES * 8) begin
        // dropped write, position holds
        upd = '{addr: '0, value: '0, last: 1'b1, ovf: 1'b1, pos: POS_W'(head)};
        pending_bytes.push_back(upd);
      end else begin
        field = int'(data) & ((1 << nbits) - 1);
        idx   = head >> 3;
        off   = head & 7;
        room  = 8 - off;
        if (idx >= BUFFER_BYTES) idx = BUFFER_BYTES - 1;
        merged = DATA_W'((int'(byte_image[idx]) & ((1 << off) - 1)) | (field << off));
        byte_image[idx] = merged;
        stream_pos = POS_W'(next_pos);
        upd = '{addr: ADDR_W'(idx), value: merged, last: (room >= nbits), ovf: 1'b0,
                pos: POS_W'(next_pos)};
        pending_bytes.push_back(upd);
        if (room < nbits) begin
          // spill into the next byte, rest of it cleared
          idx = idx + 1;
          if (idx >= BUFFER_BYTES) idx = BUFFER_BYTES - 1;
          merged = DATA_W'(field >> room);
          byte_image[idx] = merged;
          upd = '{addr: ADDR_W'(idx), value: merged, last: 1'b1, ovf: 1'b0,
                  pos: POS_W'(next_pos)};
          pending_bytes.push_back(upd);
        end
      end
    end
  endtask

  function automatic void report(input string field_name, input int unsigned want,
                                 input int unsigned got);
    $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
    fail_count++;
  endfunction

  task automatic check_byte();
    bfp_result_t want;
    if (pending_bytes.size() == 0) begin
      $error("unexpected result: byte_address %0d byte_value %0d", byte_address, byte_value);
      fail_count++;
    end else begin
      want = pending_bytes.pop_front();
      if (byte_address !== want.addr)
        report("byte_address", 32'(want.addr), 32'(byte_address));
      if (byte_value   !== want.value)
        report("byte_value", 32'(want.value), 32'(byte_value));
      if (last         !== want.last) report("last", 32'(want.last), 32'(last));
      if (overflow     !== want.ovf) report("overflow", 32'(want.ovf), 32'(overflow));
      if (bit_position !== want.pos)
        report("bit_position", 32'(want.pos), 32'(bit_position));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stream_pos = '0;
      pending_bytes.delete();
      for (int i = 0; i < BUFFER_BYTES; i++) byte_image[i] = '0;
    end else begin
      if (in_valid && in_ready) pack_field(data_byte, bit_count);
      if (out_valid && out_ready) check_byte();
    end
    pending_count = pending_bytes.size();
  end

endmodule

// ===== tb/tb_bit_field_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_field_packer_top
// Drives field transactions into the bit field packer: a directed opening,
// then random fields until the buffer fills and writes start to overflow.
// The sender bursts and pauses, the receiver stalls on its own pattern, and
// a checker beside the block tracks every byte update.
// ----------------------------------------------------------------------------
module tb_bit_field_packer_top;
  import bfp_pkg::*;

  localparam int RANDOM_FIELDS = 1850;
  localparam int DRAIN_CYCLES  = 20;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [DATA_W-1:0]  data_byte;
  logic [COUNT_W-1:0] bit_count;
  logic               out_valid;
  logic               out_ready;
  logic [ADDR_W-1:0]  byte_address;
  logic [DATA_W-1:0]  byte_value;
  logic               last;
  logic               overflow;
  logic [POS_W-1:0]   bit_position;
  int unsigned        fail_count;
  int unsigned        pending_count;

  // stimulus-side running fill, only used to aim fields at the exact end
  int unsigned        fill_bits;
  // sender burst bookkeeping
  int unsigned        burst_left;
  bit                 no_gaps;
  // receiver stall pattern
  logic [15:0]        ready_pattern;
  int unsigned        pattern_mode;
  int unsigned        pattern_left;

  bit_field_packer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .bit_count    (bit_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .last         (last),
    .overflow     (overflow),
    .bit_position (bit_position)
  );

  bfp_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .bit_count     (bit_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_address  (byte_address),
    .byte_value    (byte_value),
    .last          (last),
    .overflow      (overflow),
    .bit_position  (bit_position),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: whenever the current run ends, pick a new mode and a fresh 16-bit pattern
  // mode 0 never stalls, mode 3 stalls most of the time
  always @(negedge clk) begin
    if (rst) begin
      out_ready    <= 1'b0;
      pattern_left <= 0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode  <= $urandom_range(0, 3);
        ready_pattern <= 16'($urandom);
        pattern_left  <= 64;
        out_ready     <= 1'b1;
      end else begin
        case (pattern_mode)
          0: out_ready <= 1'b1;
          3: out_ready <= ready_pattern[0] & ready_pattern[5];
          default: out_ready <= ready_pattern[0];
        endcase
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        pattern_left  <= pattern_left - 1;
      end
    end
  end

  // keep the running fill in step with what the block should accept
  function automatic void track_fill(input logic [COUNT_W-1:0] count);
    int unsigned nbits;
    nbits = (count > MAX_COUNT) ? int'(MAX_COUNT) : int'(count);
    if (nbits != 0 && fill_bits + nbits <= BUFFER_BYTES * 8) fill_bits += nbits;
  endfunction

  // present one field and hold it until the transaction completes;
  // between bursts the sender drops valid for a random gap
  task automatic send_field(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count);
    int unsigned gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= data;
    bit_count <= count;
    do @(posedge clk); while (!in_ready);
    track_fill(count);
  endtask

  // count mix: mostly legal sizes, some saturated, some zero
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return COUNT_W'($urandom_range(1, 8));
    else if (roll < 90) return COUNT_W'($urandom_range(8, 15));
    else return '0;
  endfunction

  initial begin
    logic [DATA_W-1:0]  d;
    logic [COUNT_W-1:0] c;
    int unsigned        remaining;
    // directed fields: data, count
    logic [11:0] opening [22] = '{
      {8'hFF, 4'd3},   // high data bits must be masked
      {8'h00, 4'd0},   // zero count, no transaction out
      {8'h5A, 4'd5},   // lands exactly on the byte boundary
      {8'hFF, 4'd1},
      {8'h00, 4'd8},   // crossing with all-zero data
      {8'hFF, 4'd15},  // saturated count, crossing
      {8'hA5, 4'd9},
      {8'h80, 4'd7},
      {8'h7F, 4'd8},   // byte aligned full field
      {8'h01, 4'd6},
      {8'hC3, 4'd4},   // crossing
      {8'h55, 4'd2},
      {8'hAA, 4'd12},
      {8'hFF, 4'd4},
      {8'hFF, 4'd8},
      {8'h0F, 4'd10},
      {8'hF0, 4'd13},
      {8'h33, 4'd14},
      {8'hCC, 4'd11},
      {8'hFF, 4'd7},   // offset seven next
      {8'hFF, 4'd8},   // widest spill into the next byte
      {8'h96, 4'd0}
    };

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    data_byte  <= '0;
    bit_count  <= '0;
    fill_bits  = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_field(opening[i][11:4], opening[i][3:0]);

    // random fields; once close to the end, often pick the exact remainder
    // so the buffer fills completely, everything after that overflows
    for (int n = 0; n < RANDOM_FIELDS; n++) begin
      no_gaps = (n >= 600 && n < 850);
      d = DATA_W'($urandom_range(0, 255));
      remaining = BUFFER_BYTES * 8 - fill_bits;
      if (remaining > 0 && remaining < 8 && $urandom_range(0, 1) == 1)
        c = COUNT_W'(remaining);
      else
        c = pick_count();
      send_field(d, c);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain the result queue, then let any zero-count field settle
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
